// ===== rtl/maf_pkg.sv =====
// ----------------------------------------------------------------------------
// Moving average filter package
// Shared widths, sizes, control state encoding and divider interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package maf_pkg;

    localparam int MAX_WINDOW  = 4096;
    localparam int SAMPLE_BITS = 32;
    localparam int ADDR_W      = $clog2(MAX_WINDOW);
    localparam int WIN_W       = ADDR_W + 1;
    localparam int SUM_W       = SAMPLE_BITS + ADDR_W;
    localparam int DIV_STEPS   = SUM_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic [WIN_W-1:0] WIN_MAX   = WIN_W'(MAX_WINDOW);
    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(16);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ADD,
        ST_START,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                   start;
        logic [SUM_W-1:0]       dividend;
        logic [WIN_W-1:0]       divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [SAMPLE_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/maf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data, no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/maf_div.sv =====
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division of an unsigned sum magnitude by the sample count,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire maf_pkg::div_req_t req,
    output maf_pkg::div_rsp_t      rsp
);

    logic                          busy_reg,  busy_next;
    logic                          done_reg,  done_next;
    logic [maf_pkg::STEP_W-1:0]    step_reg,  step_next;
    logic [maf_pkg::WIN_W-1:0]     rem_reg,   rem_next;
    logic [maf_pkg::SUM_W-1:0]     quo_reg,   quo_next;
    logic [maf_pkg::WIN_W-1:0]     dvs_reg,   dvs_next;
    logic [maf_pkg::WIN_W:0]       rem_shift;
    logic [maf_pkg::WIN_W:0]       rem_diff;
    logic                          fits;

    assign rem_shift = {rem_reg, quo_reg[maf_pkg::SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign fits      = (rem_shift >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            // load dividend; quotient bits shift in from the bottom
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_diff[maf_pkg::WIN_W-1:0] : rem_shift[maf_pkg::WIN_W-1:0];
            quo_next = {quo_reg[maf_pkg::SUM_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == maf_pkg::STEP_W'(maf_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[maf_pkg::SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/moving_average_filter_core.sv =====
// From sample accept to mean on the output register: ring read, add,
// divider load, 44 bit-serial divide steps, sign fix-up; with a window length
// of zero the word is dropped and the held mean is sent. One word is in
// flight at a time; a new word is taken while a result still waits.
// Reset: window length 16, sum, count, write position and held mean zero;
// ring memory contents undefined, read data used only once the slot is written.
// ----------------------------------------------------------------------------
// Moving average filter core
// Boxcar mean over the most recent samples held in a ring memory, with a
// running sum and a bit-serial divider for the truncated mean.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_filter_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // window length register
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [maf_pkg::WIN_W-1:0]          window_length,
    // sample input
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [maf_pkg::SAMPLE_BITS-1:0] sample,
    // mean output
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [maf_pkg::SAMPLE_BITS-1:0]  mean,
    output logic                                    window_full
);

    maf_pkg::state_t state_reg, state_next;

    // filter state
    logic [maf_pkg::WIN_W-1:0]        win_reg,   win_next;
    logic signed [maf_pkg::SUM_W-1:0] sum_reg,   sum_next;
    logic [maf_pkg::WIN_W-1:0]        count_reg, count_next;
    logic [maf_pkg::ADDR_W-1:0]       wp_reg,    wp_next;
    logic [maf_pkg::SAMPLE_BITS-1:0]  held_reg,  held_next;

    // per-word holding registers
    logic signed [maf_pkg::SAMPLE_BITS-1:0] samp_reg, samp_next;
    logic [maf_pkg::ADDR_W-1:0]       pos_reg,   pos_next;
    logic                             neg_reg,   neg_next;

    // output register
    logic                             ov_reg,    ov_next;
    logic [maf_pkg::SAMPLE_BITS-1:0]  mean_reg,  mean_next;
    logic                             full_reg,  full_next;

    logic                             in_take;
    logic                             out_take;
    logic                             cfg_take;
    logic                             out_free;
    logic                             is_full;
    logic [maf_pkg::ADDR_W-1:0]       pos_now;
    logic [maf_pkg::WIN_W-1:0]        pos_inc;
    logic [maf_pkg::SUM_W-1:0]        sum_mag;
    logic [maf_pkg::SAMPLE_BITS-1:0]  signed_q;
    logic [maf_pkg::SAMPLE_BITS-1:0]  ram_rd_data;
    logic                             ram_wr_en;
    logic                             ram_rd_en;
    maf_pkg::div_req_t                div_req;
    maf_pkg::div_rsp_t                div_rsp;

    assign in_take  = in_valid && !in_stall;
    assign out_take = ov_reg && !out_stall;
    assign cfg_take = cfg_valid && cfg_ready;
    assign out_free = !ov_reg || !out_stall;
    assign is_full  = (count_reg == win_reg);

    // slot for the incoming word; wrap if the pointer ran past the window
    assign pos_now = ({1'b0, wp_reg} >= win_reg) ? '0 : wp_reg;
    assign pos_inc = {1'b0, pos_reg} + 1'b1;

    assign sum_mag  = sum_reg[maf_pkg::SUM_W-1] ? maf_pkg::SUM_W'(-sum_reg)
                                                : maf_pkg::SUM_W'(sum_reg);
    assign signed_q = neg_reg ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            maf_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    // zero window: drop the word and answer the held mean
                    state_next = (win_reg == '0) ? maf_pkg::ST_DONE : maf_pkg::ST_READ;
                end
            end
            maf_pkg::ST_READ:  state_next = maf_pkg::ST_ADD;
            maf_pkg::ST_ADD:   state_next = maf_pkg::ST_START;
            maf_pkg::ST_START: state_next = maf_pkg::ST_DIV;
            maf_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = maf_pkg::ST_DONE;
                end
            end
            maf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = maf_pkg::ST_IDLE;
                end
            end
            default: state_next = maf_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // control outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_stall         = (state_reg != maf_pkg::ST_IDLE);
        // a waiting sample word goes first; hold the window write until idle
        cfg_ready        = (state_reg == maf_pkg::ST_IDLE) && !in_valid;
        ram_rd_en        = 1'b0;
        ram_wr_en        = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = sum_mag;
        div_req.divisor  = count_reg;
        unique case (state_reg)
            maf_pkg::ST_IDLE:  ram_rd_en     = in_take;
            maf_pkg::ST_ADD:   ram_wr_en     = 1'b1;
            maf_pkg::ST_START: div_req.start = 1'b1;
            maf_pkg::ST_READ,
            maf_pkg::ST_DIV,
            maf_pkg::ST_DONE:  ram_rd_en     = 1'b0;
            default:           ram_rd_en     = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        win_next   = win_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        wp_next    = wp_reg;
        held_next  = held_reg;
        samp_next  = samp_reg;
        pos_next   = pos_reg;
        neg_next   = neg_reg;
        ov_next    = ov_reg;
        mean_next  = mean_reg;
        full_next  = full_reg;

        if (out_take)
        begin
            ov_next = 1'b0;
        end

        // window write: saturate and clear the filter, keep the held mean
        if (cfg_take)
        begin
            win_next   = (window_length > maf_pkg::WIN_MAX) ? maf_pkg::WIN_MAX
                                                            : window_length;
            sum_next   = '0;
            count_next = '0;
            wp_next    = '0;
        end

        unique case (state_reg)
            maf_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    samp_next = sample;
                    pos_next  = pos_now;
                end
            end
            maf_pkg::ST_READ:
            begin
                // window full: drop the oldest word from the sum
                if (is_full)
                begin
                    sum_next = sum_reg - maf_pkg::SUM_W'(signed'(ram_rd_data));
                end
            end
            maf_pkg::ST_ADD:
            begin
                sum_next = sum_reg + maf_pkg::SUM_W'(samp_reg);
                if (!is_full)
                begin
                    count_next = count_reg + 1'b1;
                end
                wp_next = (pos_inc >= win_reg) ? '0 : pos_inc[maf_pkg::ADDR_W-1:0];
            end
            maf_pkg::ST_START:
            begin
                neg_next = sum_reg[maf_pkg::SUM_W-1];
            end
            maf_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    held_next = signed_q;
                end
            end
            maf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    mean_next = held_reg;
                    full_next = (win_reg != '0) && is_full;
                end
            end
            default:
            begin
                ov_next = ov_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= maf_pkg::ST_IDLE;
            win_reg   <= maf_pkg::WIN_RESET;
            sum_reg   <= '0;
            count_reg <= '0;
            wp_reg    <= '0;
            held_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            win_reg   <= win_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
            wp_reg    <= wp_next;
            held_reg  <= held_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg <= samp_next;
        pos_reg  <= pos_next;
        neg_reg  <= neg_next;
        mean_reg <= mean_next;
        full_reg <= full_next;
    end

    assign out_valid   = ov_reg;
    assign mean        = mean_reg;
    assign window_full = full_reg;

    // ring of recent samples
    maf_ram #(
        .WIDTH (maf_pkg::SAMPLE_BITS),
        .DEPTH (maf_pkg::MAX_WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_reg),
        .wr_data (samp_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (pos_now),
        .rd_data (ram_rd_data)
    );

    // sum / count, one quotient bit per cycle
    maf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/maf_checker.sv =====
// ----------------------------------------------------------------------------
// Moving average filter port checker
// Watches the top level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module maf_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [maf_pkg::SAMPLE_BITS-1:0]   mean,
    input wire logic                              window_full
);

    // hold a stalled result word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mean) && $stable(window_full))
    else $error("stalled result word changed or dropped");

    // one word in flight: stall right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while one is in flight");

    // a result never appears in the cycle right after its accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

    // window register only written while no word is in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !in_stall)
    else $error("window written while busy");

endmodule

bind moving_average_filter_core maf_checker u_maf_checker (.*);

`default_nettype wire

// ===== test/maf_mean_checker.sv =====
// ----------------------------------------------------------------------------
// Moving average mean checker
// Watches the window, sample and mean channels, predicts each mean and
// window-full flag from its own copy of the filter state, and counts mismatches.
// ----------------------------------------------------------------------------
module maf_mean_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [maf_pkg::WIN_W-1:0]              window_length,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic signed [maf_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic signed [maf_pkg::SAMPLE_BITS-1:0] mean,
    input  logic                                   window_full,
    output int                                     fail_count,
    output int                                     pending,
    output int                                     means_checked,
    output int                                     full_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [maf_pkg::SAMPLE_BITS-1:0] mean;
        logic                                   full;
    } average_t;

    // filter state as seen from outside
    logic signed [maf_pkg::SAMPLE_BITS-1:0] ring [maf_pkg::MAX_WINDOW];
    logic signed [maf_pkg::SUM_W-1:0]       window_sum;
    int                                     stored;
    int                                     next_slot;
    logic signed [maf_pkg::SAMPLE_BITS-1:0] last_mean;
    logic [maf_pkg::WIN_W-1:0]              window_reg;

    average_t expected_means[$];
    average_t want;

    // Fold one sample into the window and return the mean it produces.
    function automatic average_t advance_average(
        input logic signed [maf_pkg::SAMPLE_BITS-1:0] value);
        int       span;
        int       slot;
        longint   quotient;
        average_t result;
        span = (window_reg > maf_pkg::MAX_WINDOW) ? maf_pkg::MAX_WINDOW : int'(window_reg);
        if (span != 0)
        begin
            slot = (next_slot >= span) ? 0 : next_slot;
            if (stored >= span)
            begin
                window_sum = window_sum - ring[slot] + value;
                stored     = span;
            end
            else
            begin
                window_sum = window_sum + value;
                stored     = stored + 1;
            end
            ring[slot] = value;
            next_slot  = (slot + 1 >= span) ? 0 : slot + 1;
            // signed division truncates toward zero
            quotient   = longint'(window_sum) / longint'(stored);
            last_mean  = quotient[maf_pkg::SAMPLE_BITS-1:0];
        end
        result.mean = last_mean;
        result.full = (span != 0) && (stored == span);
        return result;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    = maf_pkg::WIN_RESET;
            window_sum    = '0;
            stored        = 0;
            next_slot     = 0;
            last_mean     = '0;
            fail_count    = 0;
            means_checked = 0;
            full_results  = 0;
            expected_means.delete();
            pending       = 0;
        end
        else
        begin
            // retire the result first: it belongs to a word taken earlier
            if (out_valid && !out_stall)
            begin
                if (expected_means.size() == 0)
                begin
                    $error("mean: unexpected word, actual %0d", mean);
                    fail_count++;
                end
                else
                begin
                    want = expected_means.pop_front();
                    if (mean !== want.mean)
                    begin
                        $error("mean: expected %0d, actual %0d", want.mean, mean);
                        fail_count++;
                    end
                    if (window_full !== want.full)
                    begin
                        $error("window_full: expected %0b, actual %0b",
                               want.full, window_full);
                        fail_count++;
                    end
                    means_checked++;
                    if (want.full)
                        full_results++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                window_reg = window_length;
                window_sum = '0;
                stored     = 0;
                next_slot  = 0;
            end
            if (in_valid && !in_stall)
                expected_means.push_back(advance_average(sample));
            pending = expected_means.size();
        end
    end

endmodule

// ===== test/moving_average_filter_core_test.sv =====
// ----------------------------------------------------------------------------
// Moving average filter core testbench
// Drives directed and random samples through a series of window lengths,
// with random gaps on the sample side and random stalls on the mean side;
// a separate checker predicts every mean and flags mismatches.
// ----------------------------------------------------------------------------
module moving_average_filter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_GOAL  = 1600;
    // slowest legal word: the full divide, the longest mean stall and the
    // longest sample gap; take that for every word and then several times over
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 60;

    localparam logic signed [maf_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [maf_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN = 32'sh8000_0000;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   cfg_valid;
    logic                                   cfg_ready;
    logic [maf_pkg::WIN_W-1:0]              window_length;
    logic                                   in_valid;
    logic                                   in_stall;
    logic signed [maf_pkg::SAMPLE_BITS-1:0] sample;
    logic                                   out_valid;
    logic                                   out_stall;
    logic signed [maf_pkg::SAMPLE_BITS-1:0] mean;
    logic                                   window_full;

    int fail_count;
    int pending;
    int means_checked;
    int full_results;

    int samples_sent;
    int windows_written;
    int cycle_count;
    logic burst_mode;     // when set, the sample side never idles
    logic [maf_pkg::WIN_W-1:0] current_window;

    moving_average_filter_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .window_length (window_length),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mean          (mean),
        .window_full   (window_full)
    );

    maf_mean_checker mean_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .window_length (window_length),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mean          (mean),
        .window_full   (window_full),
        .fail_count    (fail_count),
        .pending       (pending),
        .means_checked (means_checked),
        .full_results  (full_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: end the run once the cycle count reaches the limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Idle cycles before the next sample word: mostly none or a few,
    // now and then long enough to land on any phase of the divide.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 120);
    endfunction

    // Sample values: full-range random, the two extremes, values near zero
    // and values just inside either extreme.
    function automatic logic signed [maf_pkg::SAMPLE_BITS-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom;
        else if (r < 70)
            return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
        else if (r < 85)
            return int'($urandom_range(0, 16)) - 8;
        else if (r < 93)
            return SAMPLE_MAX - int'($urandom_range(0, 255));
        else
            return SAMPLE_MIN + int'($urandom_range(0, 255));
    endfunction

    // Window lengths: mostly short so windows fill and wrap often, some
    // zero, some beyond the ring size, and some rewrites of the same value.
    function automatic logic [maf_pkg::WIN_W-1:0] pick_window();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 60)
            return maf_pkg::WIN_W'($urandom_range(1, 8));
        else if (r < 84)
            return maf_pkg::WIN_W'($urandom_range(9, 64));
        else if (r < 92)
            return maf_pkg::WIN_W'($urandom_range(65, 8191));
        else
            return current_window;
    endfunction

    // Offer one sample word; return at the falling edge after it is taken.
    // Valid stays high across back-to-back words; this task drops it only for a gap.
    task automatic send_sample(input logic signed [maf_pkg::SAMPLE_BITS-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        // hold the word until a rising edge sees no stall
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        samples_sent++;
    endtask

    // Write the window length once every mean in flight has come back.
    task automatic set_window(input logic [maf_pkg::WIN_W-1:0] value);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_valid     <= 1'b1;
        window_length <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid      <= 1'b0;
        current_window  = value;
        windows_written++;
    endtask

    // Mean side: open stretches of random length, some very long, broken
    // by stalls that are mostly short and now and then long.
    initial
    begin
        int r;
        int open_run;
        int hold;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            r        = $urandom_range(0, 99);
            open_run = (r < 10) ? $urandom_range(200, 800) : $urandom_range(1, 40);
            r        = $urandom_range(0, 99);
            if (r < 90)
                hold = $urandom_range(1, 3);
            else if (r < 97)
                hold = $urandom_range(4, 20);
            else
                hold = $urandom_range(30, 100);
            out_stall <= 1'b0;
            repeat (open_run) @(negedge clk);
            out_stall <= 1'b1;
            repeat (hold) @(negedge clk);
        end
    end

    // Stimulus
    initial
    begin
        logic [maf_pkg::WIN_W-1:0] forced_windows [5];
        logic [maf_pkg::WIN_W-1:0] next_window;
        int span;
        int phase_len;
        int phase;

        // every input known from time zero
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        window_length   = '0;
        in_valid        = 1'b0;
        sample          = '0;
        burst_mode      = 1'b0;
        samples_sent    = 0;
        windows_written = 0;
        cycle_count     = 0;
        current_window  = maf_pkg::WIN_RESET;

        // first random phases: a rewrite of the same length, the ring size,
        // the largest register value, which saturates, and a single sample
        forced_windows[0] = maf_pkg::WIN_W'(3);
        forced_windows[1] = maf_pkg::WIN_W'(3);
        forced_windows[2] = maf_pkg::WIN_MAX;
        forced_windows[3] = '1;
        forced_windows[4] = maf_pkg::WIN_W'(1);

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset window of 16. Hit both extremes and the values
        // around zero, then drive the minimum until the window fills and
        // wraps, so the sum reaches fifteen times the minimum plus one.
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample('0);
        send_sample(-1);
        send_sample(1);
        repeat (15) send_sample(SAMPLE_MIN);

        // window of zero: samples are dropped and the last mean is held
        set_window('0);
        send_sample(SAMPLE_MAX);
        send_sample(12345);
        send_sample(SAMPLE_MIN);

        // window of one: the mean follows the sample
        set_window(maf_pkg::WIN_W'(1));
        send_sample(SAMPLE_MAX);
        send_sample(-7);

        // Random phases: new window, then enough samples to fill and wrap
        // short windows at least once; long windows only start to fill.
        phase = 0;
        while (samples_sent < SAMPLE_GOAL)
        begin
            next_window = (phase < 5) ? forced_windows[phase] : pick_window();
            set_window(next_window);
            span = (next_window > maf_pkg::MAX_WINDOW) ? maf_pkg::MAX_WINDOW
                                                       : int'(next_window);
            if (span == 0)
                phase_len = $urandom_range(3, 8);
            else if (span <= 64)
                phase_len = span * 2 + $urandom_range(0, 24);
            else
                phase_len = $urandom_range(20, 80);
            // a quarter of the phases run with no idle cycles at all
            burst_mode = ($urandom_range(0, 3) == 0);
            repeat (phase_len) send_sample(pick_sample());
            phase++;
        end

        // drain: wait for every mean, then for the pipeline to go quiet
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d samples over %0d window writes (zero, wrap, saturated)",
                 samples_sent, windows_written);
        $display("checked %0d means, %0d of them with a full window",
                 means_checked, full_results);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== moving_average_filter_core.f =====
rtl/maf_pkg.sv
rtl/maf_ram.sv
rtl/maf_div.sv
rtl/moving_average_filter_core.sv
rtl/maf_checker.sv
test/maf_mean_checker.sv
test/moving_average_filter_core_test.sv
